### rtl/rcgf_pkg.sv
`default_nettype none
package rcgf_pkg;

    localparam int CHANNELS_DEF       = 4;
    localparam int COS_DEPTH_DEF      = 256;
    localparam int GAIN_FRAC_DEF      = 16;
    localparam int GAIN_W             = 20;
    localparam int SAMPLE_W           = 24;
    localparam int TIME_W             = 48;
    localparam int DUR_W              = 24;
    localparam int PHASE_W            = 32;
    localparam int COS_W              = 16;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 20'd65536;
    localparam logic [0:0] REQ_FRAME  = 1'b0;
    localparam logic [0:0] REQ_FADE   = 1'b1;

    // 32-bit turn fraction: pi = 2^31
    localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;

    // Quarter-wave cosine entry, Q1.15, via integer Taylor series.
    function automatic logic [COS_W-1:0] cos_entry(input int unsigned i, input int unsigned depth);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        longint unsigned v;
        x    = (PI_HALF_Q30 * 64'(i)) / 64'(depth);
        x2   = (x * x) >> 30;
        term = 64'd1 << 30;
        sum  = longint'(term);
        for (int k = 1; k <= 7; k++) begin
            term = (term * x2) >> 30;
            term = term / 64'((2 * k - 1) * (2 * k));
            if (k % 2 == 1) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        v = (longint'(sum) + (64'd1 << 14)) >> 15;
        if (v > 64'd32768) begin
            v = 64'd32768;
        end
        return COS_W'(v);
    endfunction

    typedef struct packed {
        logic load_in;     // capture frame samples
        logic load_fade;   // latch a fade command
        logic div_start;   // launch phase step division
        logic ramp;        // fade advances on this frame
        logic ang_mul;     // compute angle
        logic gain_upd;    // compute new gain
        logic ch_mul;      // scale one channel
        logic [1:0] ch_sel;
        logic out_load;    // capture result
        logic out_fade;    // result is for a fade command
    } t_cmd;

    typedef struct packed {
        logic div_busy;
        logic may_ramp;    // remaining nonzero and start condition met
    } t_status;

endpackage
`default_nettype wire

### rtl/rcgf_datapath.sv
`default_nettype none
module rcgf_datapath
    import rcgf_pkg::*;
#(
    parameter int CHANNELS       = CHANNELS_DEF,
    parameter int COS_TABLE_DEPTH = COS_DEPTH_DEF,
    parameter int GAIN_FRAC_BITS = GAIN_FRAC_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [GAIN_W-1:0]          i_cfg_data,
    input  wire t_cmd                       i_cmd,
    output t_status                         o_status,
    input  wire logic [4*SAMPLE_W-1:0]      i_samples,
    input  wire logic [TIME_W-1:0]          i_session_time,
    input  wire logic                       i_rolling,
    input  wire logic [GAIN_W-1:0]          i_fade_target,
    input  wire logic [DUR_W-1:0]           i_fade_duration,
    input  wire logic [TIME_W-1:0]          i_fade_start_sample,
    input  wire logic                       i_fade_now,
    output logic [4*SAMPLE_W-1:0]           o_outs,
    output logic [GAIN_W-1:0]               o_gain_now,
    output logic                            o_fading
);
    localparam int IDX_W = $clog2(COS_TABLE_DEPTH) + 1;
    localparam int DIV_CNT_W = $clog2(PHASE_W + 1);

    logic [GAIN_W-1:0]   r_cur, r_start, r_end;
    logic [DUR_W-1:0]    r_rem;
    logic [PHASE_W-1:0]  r_step;
    logic [TIME_W-1:0]   r_sched;
    logic                r_now;
    logic [PHASE_W-1:0]  r_angle;
    logic [4*SAMPLE_W-1:0] r_acc;
    logic [4*SAMPLE_W-1:0] r_smp;

    // restoring divider 2^31 / dur, one quotient bit per cycle
    logic [DUR_W:0]      r_drem;
    logic [PHASE_W-1:0]  r_dq;
    logic [DUR_W-1:0]    r_dden;
    logic [DIV_CNT_W-1:0] r_dcnt;
    logic                r_dbusy;

    logic [DUR_W-1:0] dur_fix;
    assign dur_fix = (i_fade_duration == '0) ? DUR_W'(1) : i_fade_duration;

    logic [DUR_W:0] d_shift;
    logic           d_bit;
    assign d_bit   = (r_dcnt == DIV_CNT_W'(PHASE_W)) ? 1'b1 : 1'b0;
    assign d_shift = {r_drem[DUR_W-1:0], d_bit};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dbusy <= 1'b0;
            r_dcnt  <= '0;
        end else if (i_cmd.div_start) begin
            r_dbusy <= 1'b1;
            r_dcnt  <= DIV_CNT_W'(PHASE_W);
        end else if (r_dbusy) begin
            r_dcnt <= r_dcnt - 1'b1;
            if (r_dcnt == DIV_CNT_W'(1)) begin
                r_dbusy <= 1'b0;
            end
        end
    end

    // dividend 2^31: bit fed in when count equals 32 (bit index 31)
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_drem <= '0;
            r_dq   <= '0;
            r_dden <= dur_fix;
        end else if (r_dbusy) begin
            if (d_shift >= {1'b0, r_dden}) begin
                r_drem <= d_shift - {1'b0, r_dden};
                r_dq   <= {r_dq[PHASE_W-2:0], 1'b1};
            end else begin
                r_drem <= d_shift;
                r_dq   <= {r_dq[PHASE_W-2:0], 1'b0};
            end
            if (r_dcnt == DIV_CNT_W'(1)) begin
                r_step <= (d_shift >= {1'b0, r_dden}) ? {r_dq[PHASE_W-2:0], 1'b1}
                                                      : {r_dq[PHASE_W-2:0], 1'b0};
            end
        end
    end

    assign o_status.div_busy = r_dbusy;
    assign o_status.may_ramp = (r_rem != '0) &&
        (r_now || (i_rolling && (r_sched <= i_session_time)));

    // quarter-wave table, constant contents
    logic [COS_W-1:0] cos_rom [COS_TABLE_DEPTH];
    for (genvar g = 0; g < COS_TABLE_DEPTH; g++) begin : g_cos
        assign cos_rom[g] = cos_entry(g, COS_TABLE_DEPTH);
    end

    // cosine lookup from registered angle
    logic [1:0]        quad;
    logic [IDX_W-1:0]  idx, mir, sel;
    logic [29+IDX_W:0] off_sc;
    logic [COS_W-1:0]  tab;
    logic              neg_c;
    logic [COS_W:0]    weight;   // 32768 + cos, Q1.16
    assign quad   = r_angle[31:30];
    assign off_sc = (30+IDX_W)'(r_angle[29:0]) * (30+IDX_W)'(COS_TABLE_DEPTH)
                    + ((30+IDX_W)'(1) << 29);
    assign idx    = off_sc[29+IDX_W:30];
    assign mir    = IDX_W'(COS_TABLE_DEPTH) - idx;
    assign sel    = quad[0] ? mir : idx;
    assign neg_c  = quad[0] ^ quad[1];
    assign tab    = (sel >= IDX_W'(COS_TABLE_DEPTH)) ? '0 : cos_rom[sel[IDX_W-2:0]];
    assign weight = neg_c ? ((COS_W+1)'(32768) - (COS_W+1)'(tab))
                          : ((COS_W+1)'(32768) + (COS_W+1)'(tab));

    logic              up;
    logic [GAIN_W-1:0] diff;
    logic [GAIN_W+COS_W+1:0] prod;
    logic [GAIN_W-1:0] delta;
    assign up    = r_end >= r_start;
    assign diff  = up ? (r_end - r_start) : (r_start - r_end);
    assign prod  = (GAIN_W+COS_W+2)'(diff) * (GAIN_W+COS_W+2)'(weight)
                   + (GAIN_W+COS_W+2)'(32768);
    assign delta = prod[GAIN_W+15:16];

    // channel scaling, one channel per cycle
    logic signed [SAMPLE_W-1:0] smp;
    logic [SAMPLE_W-1:0] mag;
    logic [SAMPLE_W+GAIN_W:0] sp;
    logic [SAMPLE_W+GAIN_W:0] r;
    logic [SAMPLE_W-1:0] y;
    always_comb begin
        smp = r_smp[i_cmd.ch_sel*SAMPLE_W +: SAMPLE_W];
        mag = smp[SAMPLE_W-1] ? (~smp + 1'b1) : smp;
        sp  = (SAMPLE_W+GAIN_W+1)'(mag) * (SAMPLE_W+GAIN_W+1)'(r_cur)
              + ((SAMPLE_W+GAIN_W+1)'(1) << (GAIN_FRAC_BITS - 1));
        r   = sp >> GAIN_FRAC_BITS;
        if (smp[SAMPLE_W-1]) begin
            y = (r > (SAMPLE_W+GAIN_W+1)'(24'h800000)) ? 24'h800000
                : SAMPLE_W'(~r + 1'b1);
        end else begin
            y = (r > (SAMPLE_W+GAIN_W+1)'(24'h7FFFFF)) ? 24'h7FFFFF : SAMPLE_W'(r);
        end
        if (32'(i_cmd.ch_sel) >= 32'(CHANNELS)) begin
            y = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur   <= GAIN_RESET;
            r_start <= GAIN_RESET;
            r_end   <= GAIN_RESET;
            r_rem   <= '0;
            r_sched <= '0;
            r_now   <= 1'b1;
        end else begin
            if (i_cfg_we) begin
                r_cur <= i_cfg_data;
            end
            if (i_cmd.load_fade) begin
                r_start <= r_cur;
                r_end   <= i_fade_target;
                r_rem   <= dur_fix;
                r_sched <= i_fade_start_sample;
                r_now   <= i_fade_now;
            end
            if (i_cmd.ramp) begin
                r_rem <= r_rem - 1'b1;
            end
            if (i_cmd.gain_upd) begin
                r_cur <= up ? (r_start + delta) : (r_start - delta);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_smp <= i_samples;
        end
        if (i_cmd.ang_mul) begin
            r_angle <= PHASE_W'(PHASE_W'(r_rem) * r_step);
        end
        if (i_cmd.ch_mul) begin
            r_acc[i_cmd.ch_sel*SAMPLE_W +: SAMPLE_W] <= y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_outs     <= i_cmd.out_fade ? '0 : r_acc;
            o_gain_now <= r_cur;
            o_fading   <= i_cmd.out_fade ? 1'b1 : (r_rem != '0);
        end
    end
endmodule
`default_nettype wire

### rtl/rcgf_ctrl.sv
`default_nettype none
module rcgf_ctrl
    import rcgf_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    input  wire logic     i_req_type,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  wire logic     i_out_stall,
    input  wire t_status  i_status,
    output t_cmd          o_cmd
);
    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_DIV   = 7'b0000010,
        S_ANG   = 7'b0000100,
        S_GAIN  = 7'b0001000,
        S_CH    = 7'b0010000,
        S_OUT   = 7'b0100000,
        S_WAIT  = 7'b1000000
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_ch, n_ch;
    logic       r_ovalid, n_ovalid;
    logic       r_fade, n_fade;
    logic       acc_in;

    assign o_in_stall  = (r_state != S_IDLE);
    assign acc_in      = i_in_valid && (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;

    always_comb begin
        n_state  = r_state;
        n_ch     = r_ch;
        n_ovalid = r_ovalid;
        n_fade   = r_fade;
        o_cmd    = '0;
        o_cmd.ch_sel = r_ch;
        if (r_ovalid && !i_out_stall) begin
            n_ovalid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (acc_in) begin
                    o_cmd.load_in = 1'b1;
                    if (i_req_type == REQ_FADE) begin
                        o_cmd.load_fade = 1'b1;
                        o_cmd.div_start = 1'b1;
                        n_fade  = 1'b1;
                        n_state = S_DIV;
                    end else if (i_status.may_ramp) begin
                        o_cmd.ramp    = 1'b1;
                        n_fade  = 1'b0;
                        n_state = S_ANG;
                    end else begin
                        n_fade  = 1'b0;
                        n_ch    = '0;
                        n_state = S_CH;
                    end
                end
            end
            S_DIV: begin
                if (!i_status.div_busy) begin
                    n_state = S_OUT;
                end
            end
            S_ANG: begin
                o_cmd.ang_mul = 1'b1;
                n_state = S_GAIN;
            end
            S_GAIN: begin
                o_cmd.gain_upd = 1'b1;
                n_ch    = '0;
                n_state = S_CH;
            end
            S_CH: begin
                o_cmd.ch_mul = 1'b1;
                n_ch = r_ch + 1'b1;
                if (r_ch == 2'd3) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_ovalid || !i_out_stall) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_fade = r_fade;
                    n_ovalid = 1'b1;
                    n_state  = S_WAIT;
                end
            end
            S_WAIT: begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ch     <= '0;
            r_ovalid <= 1'b0;
            r_fade   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ch     <= n_ch;
            r_ovalid <= n_ovalid;
            r_fade   <= n_fade;
        end
    end
endmodule
`default_nettype wire

### rtl/raised_cosine_gain_fade.sv
`default_nettype none
// Four-channel gain stage with a scheduled raised-cosine fade. One transaction
// in, one out; the samples of a frame are captured when it is accepted. The
// result of a frame is loaded after the one shared multiplier has scaled each
// channel in turn; while a fade ramps, angle multiply and gain update come
// first. After a fade command the result is loaded once the bit-serial divider
// has computed the phase step. The input stays stalled from acceptance through
// a wait state after the result is loaded. A result not yet taken holds the
// next one in its last step. The result sits in an output register until
// taken. i_cfg_we loads the current gain; write it only while idle.
module raised_cosine_gain_fade
    import rcgf_pkg::*;
#(
    parameter int CHANNELS        = CHANNELS_DEF,
    parameter int COS_TABLE_DEPTH = COS_DEPTH_DEF,
    parameter int GAIN_FRAC_BITS  = GAIN_FRAC_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [GAIN_W-1:0]          i_cfg_data,
    input  wire logic                       i_valid,
    output logic                            o_stall,
    input  wire logic                       i_req_type,
    input  wire logic signed [SAMPLE_W-1:0] i_sample_0,
    input  wire logic signed [SAMPLE_W-1:0] i_sample_1,
    input  wire logic signed [SAMPLE_W-1:0] i_sample_2,
    input  wire logic signed [SAMPLE_W-1:0] i_sample_3,
    input  wire logic [TIME_W-1:0]          i_session_time,
    input  wire logic                       i_rolling,
    input  wire logic [GAIN_W-1:0]          i_fade_target,
    input  wire logic [DUR_W-1:0]           i_fade_duration,
    input  wire logic [TIME_W-1:0]          i_fade_start_sample,
    input  wire logic                       i_fade_now,
    output logic                            o_valid,
    input  wire logic                       i_stall,
    output logic signed [SAMPLE_W-1:0]      o_out_0,
    output logic signed [SAMPLE_W-1:0]      o_out_1,
    output logic signed [SAMPLE_W-1:0]      o_out_2,
    output logic signed [SAMPLE_W-1:0]      o_out_3,
    output logic [GAIN_W-1:0]               o_gain_now,
    output logic                            o_fading
);
    t_cmd    cmd;
    t_status status;
    logic [4*SAMPLE_W-1:0] outs;

    rcgf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .i_req_type  (i_req_type),
        .o_in_stall  (o_stall),
        .o_out_valid (o_valid),
        .i_out_stall (i_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    rcgf_datapath #(
        .CHANNELS        (CHANNELS),
        .COS_TABLE_DEPTH (COS_TABLE_DEPTH),
        .GAIN_FRAC_BITS  (GAIN_FRAC_BITS)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_data          (i_cfg_data),
        .i_cmd               (cmd),
        .o_status            (status),
        .i_samples           ({i_sample_3, i_sample_2, i_sample_1, i_sample_0}),
        .i_session_time      (i_session_time),
        .i_rolling           (i_rolling),
        .i_fade_target       (i_fade_target),
        .i_fade_duration     (i_fade_duration),
        .i_fade_start_sample (i_fade_start_sample),
        .i_fade_now          (i_fade_now),
        .o_outs              (outs),
        .o_gain_now          (o_gain_now),
        .o_fading            (o_fading)
    );

    assign o_out_0 = outs[0*SAMPLE_W +: SAMPLE_W];
    assign o_out_1 = outs[1*SAMPLE_W +: SAMPLE_W];
    assign o_out_2 = outs[2*SAMPLE_W +: SAMPLE_W];
    assign o_out_3 = outs[3*SAMPLE_W +: SAMPLE_W];
endmodule
`default_nettype wire

### rtl/rcgf_checker.sv
`default_nettype none
module rcgf_checker
    import rcgf_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_valid,
    input wire logic              o_stall,
    input wire logic              o_valid,
    input wire logic              i_stall,
    input wire logic [GAIN_W-1:0] o_gain_now,
    input wire logic              o_fading,
    input wire logic [SAMPLE_W-1:0] o_out_0
);
    // a stalled result must hold
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_gain_now))
        else $error("result changed under stall");

    // input is stalled in the cycle after a transaction is accepted
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input not busy after accept");

    // zero gain gives silence, fade command results included
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_gain_now == '0 |-> o_out_0 == '0)
        else $error("nonzero sample at zero gain");

    a_nodup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall |=> !o_valid || o_stall)
        else $error("result repeated");
endmodule

bind raised_cosine_gain_fade rcgf_checker u_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_valid    (i_valid),
    .o_stall    (o_stall),
    .o_valid    (o_valid),
    .i_stall    (i_stall),
    .o_gain_now (o_gain_now),
    .o_fading   (o_fading),
    .o_out_0    (o_out_0)
);
`default_nettype wire
